>>> rtl/core/etl_pkg.sv
`timescale 1ns / 1ps

package etl_pkg;

  // Default cap on the character index
  localparam int unsigned MAX_TEXT_LEN_DEF = 65535;

  localparam int CH_W   = 8;
  localparam int KIND_W = 4;
  localparam int POS_W  = 16;
  localparam int ERR_W  = 2;
  // kind + pos + len + err = 38 bits, padded to whole bytes
  localparam int TDATA_W = 40;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LOG    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_SIN    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_COS    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_MUL    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_DIV    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_POW    = 4'd9;
  localparam logic [KIND_W-1:0] KIND_OPEN   = 4'd10;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 4'd11;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 4'd12;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd13;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd14;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NUMBER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CHAR   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len;
    logic [ERR_W-1:0]  err;
    logic              last;
  } token_t;

  function automatic logic is_numeral(input logic [CH_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == " ") || (c == 8'h0D) || (c == 8'h0A) || (c == 8'h09);
  endfunction

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // Single-character operators (assign included)
  function automatic logic is_op(input logic [CH_W-1:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "^") ||
           (c == "(") || (c == ")") || (c == "=");
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    k = KIND_ASSIGN;
    unique case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_MUL;
      "/":     k = KIND_DIV;
      "^":     k = KIND_POW;
      "(":     k = KIND_OPEN;
      ")":     k = KIND_CLOSE;
      default: k = KIND_ASSIGN;
    endcase
    return k;
  endfunction

  // Characters that close an identifier; '=' deliberately does not
  function automatic logic is_ident_end(input logic [CH_W-1:0] c);
    return (c == 8'h00) || is_space(c) || is_numeral(c) ||
           ((c != "=") && is_op(c));
  endfunction

  // Keyword text: row 0 log, row 1 sin, row 2 cos
  function automatic logic [CH_W-1:0] kw_char(input logic [1:0] k, input logic [1:0] idx);
    logic [CH_W-1:0] r;
    r = 8'h00;
    unique case ({k, idx})
      4'b00_00: r = "l";
      4'b00_01: r = "o";
      4'b00_10: r = "g";
      4'b01_00: r = "s";
      4'b01_01: r = "i";
      4'b01_10: r = "n";
      4'b10_00: r = "c";
      4'b10_01: r = "o";
      4'b10_10: r = "s";
      default:  r = 8'h00;
    endcase
    return r;
  endfunction

  // Drop keyword candidates that do not match character c at index idx
  function automatic logic [2:0] alive_upd(input logic [2:0] alive,
                                           input logic [CH_W-1:0] c,
                                           input logic [POS_W-1:0] idx);
    logic [2:0] r;
    r = 3'b000;
    if (idx < 16'd3) begin
      for (int k = 0; k < 3; k++) begin
        r[k] = alive[k] && (kw_char(2'(k), idx[1:0]) == c);
      end
    end
    return r;
  endfunction

  function automatic token_t make_tok(input logic [KIND_W-1:0] kind,
                                      input logic [POS_W-1:0] pos,
                                      input logic [POS_W:0] len,
                                      input logic [ERR_W-1:0] err);
    token_t t;
    t.kind = kind;
    t.pos  = pos;
    t.len  = len[POS_W] ? {POS_W{1'b1}} : len[POS_W-1:0];
    t.err  = err;
    t.last = 1'b0;
    return t;
  endfunction

endpackage

>>> rtl/core/expression_token_lexer.sv
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents
// s_axis   in   8      tdata: ch
// m_axis   out  40     tdata: token_kind, token_pos, token_len, error_code; tlast: run_last
//
// One character is taken per cycle; its tokens (none, one or two) are written
// into a four-entry result queue at that edge and show on m_axis from the next
// cycle, one transaction per cycle while m_axis_tready is high. s_axis_tready
// drops while fewer than two queue entries are free; with m_axis_tready held
// high the queue never holds more than two tokens, so the input runs without stalls.
// Reset (rst, synchronous) returns the lexer to idle at index 0 and empties the queue.

module expression_token_lexer #(
  parameter int unsigned MAX_TEXT_LEN = etl_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [etl_pkg::CH_W-1:0]    s_axis_tdata,   // [7:0] ch
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [3:0] token_kind, [19:4] token_pos, [35:20] token_len, [37:36] error_code
  output logic [etl_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast    // run_last
);
  import etl_pkg::*;

  localparam logic [POS_W-1:0] POS_CAP =
    (MAX_TEXT_LEN < 65535) ? POS_W'(MAX_TEXT_LEN) : {POS_W{1'b1}};
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    M_IDLE, M_NUM, M_AFTER_E, M_AFTER_SIGN, M_AFTER_POINT, M_IDENT, M_DROP
  } mode_t;

  mode_t            mode, mode_next;
  logic [POS_W-1:0] char_position, pos_next;
  logic [POS_W-1:0] token_start, start_next;
  logic [2:0]       keyword_alive, alive_next;
  logic             point_seen, point_next;
  logic             exponent_seen, exp_next;

  token_t           queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count, count_next;

  logic             s_accept, m_accept;
  logic [CH_W-1:0]  c;
  logic [POS_W-1:0] len;
  logic [POS_W:0]   len_w, len_p1;
  logic             again;
  token_t           res0, res1, idle_res;
  logic             idle_emit;
  logic [1:0]       n_mode, n_push;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;
  assign c        = s_axis_tdata;
  assign len      = (char_position >= token_start) ? (char_position - token_start) : '0;
  assign len_w    = {1'b0, len};
  assign len_p1   = len_w + 1'b1;

  // Per-character scan: state update and up to two tokens
  always_comb begin
    mode_next  = mode;
    start_next = token_start;
    alive_next = keyword_alive;
    point_next = point_seen;
    exp_next   = exponent_seen;
    again      = 1'b0;
    n_mode     = 2'd0;
    res0       = make_tok(KIND_ERROR, token_start, len_w, ERR_NUMBER);
    idle_emit  = 1'b0;
    idle_res   = make_tok(KIND_END, char_position, '0, ERR_NONE);

    unique case (mode)
      M_NUM: begin
        if (is_numeral(c)) begin
          mode_next = M_NUM;
        end else if (c == "e" || c == "E") begin
          if (exponent_seen) begin
            n_mode    = 2'd1;
            mode_next = M_DROP;
          end else begin
            exp_next  = 1'b1;
            mode_next = M_AFTER_E;
          end
        end else if (c == ".") begin
          if (exponent_seen || point_seen) begin
            res0      = make_tok(KIND_ERROR, token_start, len_p1, ERR_NUMBER);
            n_mode    = 2'd1;
            mode_next = M_DROP;
          end else begin
            mode_next = M_AFTER_POINT;
          end
        end else begin
          res0      = make_tok(KIND_NUMBER, token_start, len_w, ERR_NONE);
          n_mode    = 2'd1;
          mode_next = M_IDLE;
          again     = 1'b1;
        end
      end
      M_AFTER_E: begin
        if (c == "+" || c == "-") begin
          mode_next = M_AFTER_SIGN;
        end else if (is_numeral(c)) begin
          mode_next = M_NUM;
        end else begin
          n_mode    = 2'd1;
          mode_next = M_DROP;
        end
      end
      M_AFTER_SIGN: begin
        if (is_numeral(c)) begin
          mode_next = M_NUM;
        end else begin
          n_mode    = 2'd1;
          mode_next = M_DROP;
        end
      end
      M_AFTER_POINT: begin
        if (is_numeral(c)) begin
          point_next = 1'b1;
          mode_next  = M_NUM;
        end else begin
          n_mode    = 2'd1;
          mode_next = M_DROP;
        end
      end
      M_IDENT: begin
        if (is_ident_end(c)) begin
          // keyword only for a three-character lexeme that still matches
          if (len == 16'd3 && keyword_alive[0]) begin
            res0 = make_tok(KIND_LOG, token_start, len_w, ERR_NONE);
          end else if (len == 16'd3 && keyword_alive[1]) begin
            res0 = make_tok(KIND_SIN, token_start, len_w, ERR_NONE);
          end else if (len == 16'd3 && keyword_alive[2]) begin
            res0 = make_tok(KIND_COS, token_start, len_w, ERR_NONE);
          end else begin
            res0 = make_tok(KIND_IDENT, token_start, len_w, ERR_NONE);
          end
          n_mode    = 2'd1;
          mode_next = M_IDLE;
          again     = 1'b1;
        end else begin
          alive_next = alive_upd(keyword_alive, c, len);
        end
      end
      M_DROP: begin
        mode_next = M_DROP;
      end
      default: begin
        // idle, and any unused code
        mode_next = M_IDLE;
        again     = 1'b1;
      end
    endcase

    // Between tokens: skip a space, start a token, or emit an end token or a one-character one
    if (again) begin
      if (c == 8'h00) begin
        idle_emit = 1'b1;
      end else if (is_space(c)) begin
        idle_emit = 1'b0;
      end else if (is_numeral(c)) begin
        start_next = char_position;
        point_next = 1'b0;
        exp_next   = 1'b0;
        mode_next  = M_NUM;
      end else if (is_op(c)) begin
        idle_emit = 1'b1;
        idle_res  = make_tok(op_kind(c), char_position, 17'd1, ERR_NONE);
      end else if (is_letter(c)) begin
        start_next = char_position;
        alive_next = alive_upd(3'b111, c, '0);
        mode_next  = M_IDENT;
      end else begin
        idle_emit = 1'b1;
        idle_res  = make_tok(KIND_ERROR, char_position, 17'd1, ERR_CHAR);
        mode_next = M_DROP;
      end
    end

    // Place tokens in order and mark the last one
    res1   = idle_res;
    n_push = n_mode;
    if (idle_emit) begin
      if (n_mode == 2'd0) begin
        res0 = idle_res;
      end
      n_push = n_mode + 2'd1;
    end
    if (n_push == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end

    // Terminator restarts; otherwise the index advances up to the cap
    pos_next = char_position;
    if (c == 8'h00) begin
      mode_next  = M_IDLE;
      pos_next   = '0;
      start_next = '0;
      alive_next = 3'b111;
      point_next = 1'b0;
      exp_next   = 1'b0;
    end else if (char_position < POS_CAP) begin
      pos_next = char_position + 1'b1;
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      char_position <= '0;
      token_start   <= '0;
      keyword_alive <= 3'b111;
      point_seen    <= 1'b0;
      exponent_seen <= 1'b0;
    end else if (s_accept) begin
      mode          <= mode_next;
      char_position <= pos_next;
      token_start   <= start_next;
      keyword_alive <= alive_next;
      point_seen    <= point_next;
      exponent_seen <= exp_next;
    end
  end

  // Result queue
  always_comb begin
    count_next = count;
    if (s_accept) begin
      count_next = count_next + {1'b0, n_push};
    end
    if (m_accept) begin
      count_next = count_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s_accept) begin
        wr_ptr <= wr_ptr + QPTR_W'(n_push);
      end
      if (m_accept) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && n_push != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (s_accept && n_push == 2'd2) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

  assign s_axis_tready = (count <= (QPTR_W + 1)'(QDEPTH - 2));
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {2'b00, queue[rd_ptr].err, queue[rd_ptr].len,
                          queue[rd_ptr].pos, queue[rd_ptr].kind};
  assign m_axis_tlast  = queue[rd_ptr].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QDEPTH))
    else $error("result queue overfilled");

  a_term_restart: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_axis_tdata == 8'h00) |=> (char_position == '0 && mode == M_IDLE))
    else $error("terminator did not restart the scanner");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (s_accept && mode == M_DROP) |=> (count == $past(count_next)) &&
      ($past(n_push) == 2'd0))
    else $error("token produced while dropping input");
`endif

endmodule
